// ===== rtl/spi_write_then_read_queue_core_assert.svh =====
// Assertion macros for the SPI write-then-read transfer queue.
`ifndef SPI_WRITE_THEN_READ_QUEUE_CORE_ASSERT_SVH
`define SPI_WRITE_THEN_READ_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define SWTRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swtrq: implication check failed");

// Next-cycle implication, disabled during reset
`define SWTRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swtrq: next-cycle check failed");

`else

`define SWTRQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SWTRQ_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/swtrq_pkg.sv =====
// Shared constants and types of the SPI write-then-read transfer queue.
`timescale 1ns / 1ps

package swtrq_pkg;

  // Field widths of the channels
  localparam int ACTION_W = 2;
  localparam int LEN_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 16;
  localparam int PH_W     = 3;

  // Parameter defaults
  localparam int SLOTS_DEF    = 2;
  localparam int LEN_BITS_DEF = 16;

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_QUEUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POLL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TX    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RX    = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEND     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STORE    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BEGIN    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 3'd6;
  localparam logic [KIND_W-1:0] KIND_DRAIN    = 3'd7;

  // Slot phases
  localparam logic [PH_W-1:0] PH_FREE   = 3'd0;
  localparam logic [PH_W-1:0] PH_QUEUED = 3'd1;
  localparam logic [PH_W-1:0] PH_XFER   = 3'd2;
  localparam logic [PH_W-1:0] PH_DRAIN  = 3'd3;
  localparam logic [PH_W-1:0] PH_DONE   = 3'd4;

  // One result transaction
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              slot;
    logic [BYTE_W-1:0] byte_out;
    logic [POS_W-1:0]  position;
    logic              from_buffer;
    logic              read_last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;
    logic load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;
  } dp_stat_t;

endpackage

// ===== rtl/swtrq_in_if.sv =====
// Input channel of the transfer queue: action and request fields.
`timescale 1ns / 1ps

interface swtrq_in_if;
  logic                          valid;
  logic                          ready;
  logic [swtrq_pkg::ACTION_W-1:0] action;
  logic [swtrq_pkg::LEN_W-1:0]    out_len;
  logic [swtrq_pkg::LEN_W-1:0]    in_len;
  logic [swtrq_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, action, out_len, in_len, data_byte, input ready);
  modport sink   (input valid, action, out_len, in_len, data_byte, output ready);
endinterface

// ===== rtl/swtrq_out_if.sv =====
// Result channel of the transfer queue.
`timescale 1ns / 1ps

interface swtrq_out_if;
  logic                         valid;
  logic                         ready;
  logic [swtrq_pkg::KIND_W-1:0] kind;
  logic                         slot;
  logic [swtrq_pkg::BYTE_W-1:0] byte_out;
  logic [swtrq_pkg::POS_W-1:0]  position;
  logic                         from_buffer;
  logic                         read_last;

  modport source (output valid, kind, slot, byte_out, position, from_buffer, read_last,
                  input ready);
  modport sink   (input valid, kind, slot, byte_out, position, from_buffer, read_last,
                  output ready);
endinterface

// ===== rtl/spi_write_then_read_queue_core.sv =====
// SPI write-then-read transfer queue: sequences byte events over a slot table.
//
// Channels: in_chan carries one event per transaction (queue request, task poll,
// transmit event, received byte); out_chan carries at most one result per event
// (accepted, rejected, send byte, store byte, begin, complete, drain).
// Events that give nothing (an idle poll, a skipped receive byte, a transmit in
// drain) are absorbed without a result transaction.
// A result is registered and appears on out_chan in the cycle after its event is taken.
// Throughput: one event per cycle while out_chan is not stalled; the slot table,
// lowest-slot search and the counter decrement for the selected slot are combinational.
// The result register is the only buffer: while it holds a result and the
// receiver stalls (out_chan.ready low), in_chan.ready stays low; in_chan.ready
// follows out_chan.ready in the cycle the register is emptied.
// Reset (rst_n low, synchronous): all slots free, no active transfer, no result
// pending. Slot counters are loaded by each accepted queue request.
`timescale 1ns / 1ps
`include "spi_write_then_read_queue_core_assert.svh"

module spi_write_then_read_queue_core #(
  parameter int SLOTS    = swtrq_pkg::SLOTS_DEF,
  parameter int LEN_BITS = swtrq_pkg::LEN_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  swtrq_in_if.sink   in_chan,
  swtrq_out_if.source out_chan
);
  import swtrq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  result_t  res;
  logic     in_ready;
  logic     out_valid;

  swtrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swtrq_dp #(
    .SLOTS    (SLOTS),
    .LEN_BITS (LEN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .action    (in_chan.action),
    .out_len   (in_chan.out_len),
    .in_len    (in_chan.in_len),
    .data_byte (in_chan.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .res_out   (res)
  );

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid;
  assign out_chan.kind        = res.kind;
  assign out_chan.slot        = res.slot;
  assign out_chan.byte_out    = res.byte_out;
  assign out_chan.position    = res.position;
  assign out_chan.from_buffer = res.from_buffer;
  assign out_chan.read_last   = res.read_last;

  // Input is held off only by a pending result that is not being taken
  `SWTRQ_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_chan.ready, out_chan.valid && !out_chan.ready)

  // A taken result with no new event behind it empties the register
  `SWTRQ_ASSERT_NXT(a_drain_out, clk, rst_n, out_chan.valid && out_chan.ready && !in_chan.valid, !out_chan.valid)

  // Every queue request is answered with accepted or rejected
  `SWTRQ_ASSERT_NXT(a_queue_answer, clk, rst_n, in_chan.valid && in_chan.ready && (in_chan.action == ACT_QUEUE), out_chan.valid && ((out_chan.kind == KIND_ACCEPT) || (out_chan.kind == KIND_REJECT)))

endmodule

// ===== rtl/swtrq_ctrl.sv =====
// Controller: input handshake and result register occupancy.
`timescale 1ns / 1ps

module swtrq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  swtrq_pkg::dp_stat_t stat,
  output swtrq_pkg::ctl_cmd_t cmd
);
  import swtrq_pkg::*;

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic fire;

  // Take a transaction when the result register is empty or being emptied
  assign in_ready  = (state_r == ST_EMPTY) || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = (state_r == ST_FULL);

  assign cmd.exec = fire;
  assign cmd.load = fire && stat.has_result;

  // Track whether a result waits in the output register
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: begin
        if (fire && stat.has_result) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (out_ready && !(fire && stat.has_result)) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/swtrq_dp.sv =====
// Datapath: slot table, active transfer, result computation and register.
`timescale 1ns / 1ps

module swtrq_dp #(
  parameter int SLOTS    = swtrq_pkg::SLOTS_DEF,
  parameter int LEN_BITS = swtrq_pkg::LEN_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [swtrq_pkg::ACTION_W-1:0]  action,
  input  logic [swtrq_pkg::LEN_W-1:0]     out_len,
  input  logic [swtrq_pkg::LEN_W-1:0]     in_len,
  input  logic [swtrq_pkg::BYTE_W-1:0]    data_byte,
  input  swtrq_pkg::ctl_cmd_t             cmd,
  output swtrq_pkg::dp_stat_t             stat,
  output swtrq_pkg::result_t              res_out
);
  import swtrq_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Slot table: phases are control state, counters are loaded on queue and stepped by events
  logic [PH_W-1:0]     phase_r       [SLOTS];
  logic [PH_W-1:0]     phase_nxt     [SLOTS];
  logic [LEN_BITS-1:0] write_left_r  [SLOTS];
  logic [LEN_BITS-1:0] filler_left_r [SLOTS];
  logic [LEN_BITS-1:0] skip_left_r   [SLOTS];
  logic [LEN_BITS-1:0] read_left_r   [SLOTS];
  logic [LEN_BITS-1:0] write_pos_r   [SLOTS];
  logic [LEN_BITS-1:0] read_pos_r    [SLOTS];

  logic [SLOT_W-1:0] active_idx_r;
  logic [SLOT_W-1:0] active_idx_nxt;
  logic              active_vld_r;
  logic              active_vld_nxt;

  logic [SLOTS-1:0]  free_mask;
  logic [SLOTS-1:0]  queued_mask;
  logic [SLOTS-1:0]  queued2_mask;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              q_found;
  logic [SLOT_W-1:0] q_idx;
  logic              q2_found;
  logic [SLOT_W-1:0] q2_idx;

  logic [SLOT_W-1:0]   sel_idx;
  logic [PH_W-1:0]     rd_phase;
  logic [LEN_BITS-1:0] rd_wl;
  logic [LEN_BITS-1:0] rd_fl;
  logic [LEN_BITS-1:0] rd_sk;
  logic [LEN_BITS-1:0] rd_rl;
  logic [LEN_BITS-1:0] rd_wp;
  logic [LEN_BITS-1:0] rd_rp;
  logic [LEN_BITS-1:0] olen;
  logic [LEN_BITS-1:0] ilen;

  logic    q_we;
  logic    wr_step;
  logic    fill_step;
  logic    skip_step;
  logic    rd_step;
  result_t res;
  logic    res_vld;
  result_t res_r;

  assign olen = LEN_BITS'(out_len);
  assign ilen = LEN_BITS'(in_len);

  // Decode slot phases into free and queued masks
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_mask[i]   = (phase_r[i] == PH_FREE);
      queued_mask[i] = (phase_r[i] == PH_QUEUED);
    end
  end

  // Find the lowest free slot and the lowest queued slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    q_found    = 1'b0;
    q_idx      = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      if (queued_mask[i]) begin
        q_found = 1'b1;
        q_idx   = SLOT_W'(i);
      end
    end
  end

  // Find the lowest queued slot other than the working one
  always_comb begin
    q2_found = 1'b0;
    q2_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      queued2_mask[i] = queued_mask[i] && (SLOT_W'(i) != sel_idx);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (queued2_mask[i]) begin
        q2_found = 1'b1;
        q2_idx   = SLOT_W'(i);
      end
    end
  end

  // Select the working slot: the active one, or the lowest queued one
  assign sel_idx  = active_vld_r ? active_idx_r : q_idx;
  assign rd_phase = phase_r[sel_idx];
  assign rd_wl    = write_left_r[sel_idx];
  assign rd_fl    = filler_left_r[sel_idx];
  assign rd_sk    = skip_left_r[sel_idx];
  assign rd_rl    = read_left_r[sel_idx];
  assign rd_wp    = write_pos_r[sel_idx];
  assign rd_rp    = read_pos_r[sel_idx];

  // Work out the result and the next control state for one transaction
  always_comb begin
    for (int i = 0; i < SLOTS; i++) phase_nxt[i] = phase_r[i];
    active_idx_nxt = active_idx_r;
    active_vld_nxt = active_vld_r;
    q_we      = 1'b0;
    wr_step   = 1'b0;
    fill_step = 1'b0;
    skip_step = 1'b0;
    rd_step   = 1'b0;
    res       = '0;
    res_vld   = 1'b0;

    case (action)
      ACT_QUEUE: begin
        res_vld = 1'b1;
        if (free_found) begin
          phase_nxt[free_idx] = PH_QUEUED;
          q_we     = 1'b1;
          res.kind = KIND_ACCEPT;
          res.slot = free_idx[0];
        end else begin
          res.kind = KIND_REJECT;
        end
      end
      ACT_POLL: begin
        if (active_vld_r || q_found) begin
          active_idx_nxt = sel_idx;
          active_vld_nxt = 1'b1;
          res.slot       = sel_idx[0];
          case (rd_phase)
            PH_QUEUED: begin
              res_vld = 1'b1;
              if (rd_wl == '0 && rd_rl == '0) begin
                // Empty transfer: free it and hand over to the next queued slot
                phase_nxt[sel_idx] = PH_FREE;
                active_vld_nxt     = q2_found;
                if (q2_found) active_idx_nxt = q2_idx;
                res.kind = KIND_COMPLETE;
              end else begin
                phase_nxt[sel_idx] = PH_XFER;
                res.kind = KIND_BEGIN;
              end
            end
            PH_DONE: begin
              res_vld            = 1'b1;
              phase_nxt[sel_idx] = PH_FREE;
              active_vld_nxt     = q2_found;
              if (q2_found) active_idx_nxt = q2_idx;
              res.kind = KIND_COMPLETE;
            end
            default: ;
          endcase
        end
      end
      ACT_TX: begin
        if (active_vld_r) begin
          res.slot = sel_idx[0];
          case (rd_phase)
            PH_DRAIN: phase_nxt[sel_idx] = PH_DONE;
            PH_XFER: begin
              res_vld = 1'b1;
              res.kind = KIND_SEND;
              if (rd_wl != '0) begin
                wr_step          = 1'b1;
                res.byte_out     = data_byte;
                res.position     = POS_W'(rd_wp);
                res.from_buffer  = 1'b1;
              end else if (rd_fl != '0) begin
                fill_step = 1'b1;
              end else begin
                phase_nxt[sel_idx] = PH_DRAIN;
                res.kind = KIND_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end
      ACT_RX: begin
        if (active_vld_r && (rd_phase inside {PH_XFER, PH_DRAIN, PH_DONE})) begin
          res.slot = sel_idx[0];
          if (rd_sk != '0) begin
            skip_step = 1'b1;
          end else if (rd_rl != '0) begin
            rd_step       = 1'b1;
            res_vld       = 1'b1;
            res.kind      = KIND_STORE;
            res.byte_out  = data_byte;
            res.position  = POS_W'(rd_rp);
            res.read_last = (rd_rl == LEN_BITS'(1));
          end
        end
      end
      default: ;
    endcase
  end

  assign stat.has_result = res_vld;
  assign res_out         = res_r;

  // Update phases and the active transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) phase_r[i] <= PH_FREE;
      active_idx_r <= '0;
      active_vld_r <= 1'b0;
    end else if (cmd.exec) begin
      for (int i = 0; i < SLOTS; i++) phase_r[i] <= phase_nxt[i];
      active_idx_r <= active_idx_nxt;
      active_vld_r <= active_vld_nxt;
    end
  end

  // Load new requests and advance the per-slot counters
  always_ff @(posedge clk) begin
    if (cmd.exec && q_we) begin
      write_left_r[free_idx]  <= olen;
      filler_left_r[free_idx] <= ilen;
      skip_left_r[free_idx]   <= olen;
      read_left_r[free_idx]   <= ilen;
      write_pos_r[free_idx]   <= '0;
      read_pos_r[free_idx]    <= '0;
    end
    if (cmd.exec && wr_step) begin
      write_left_r[sel_idx] <= rd_wl - LEN_BITS'(1);
      write_pos_r[sel_idx]  <= rd_wp + LEN_BITS'(1);
    end
    if (cmd.exec && fill_step) filler_left_r[sel_idx] <= rd_fl - LEN_BITS'(1);
    if (cmd.exec && skip_step) skip_left_r[sel_idx] <= rd_sk - LEN_BITS'(1);
    if (cmd.exec && rd_step) begin
      read_left_r[sel_idx] <= rd_rl - LEN_BITS'(1);
      read_pos_r[sel_idx]  <= rd_rp + LEN_BITS'(1);
    end
  end

  // Hold the result for the output channel
  always_ff @(posedge clk) begin
    if (cmd.load) res_r <= res;
  end

endmodule
